>>> rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg: closest point on segment, shared constants
// Default widths and the width helpers used by cps_dot, cps_fin and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

	localparam int CPS_COORD_BITS = 32;
	localparam int CPS_FRAC_BITS  = 16;

	// coordinate difference, one bit over a coordinate
	function automatic int cps_diff_w(input int cb);
		return cb + 1;
	endfunction

	// dot(d,d) and |dot(e,d)|: three products of magnitude up to 2^(2cb)
	function automatic int cps_dot_w(input int cb);
		return 2 * cb + 2;
	endfunction

	// |t| bound: |e|/|d| < 2^(cb+1), scaled by 2^fb, plus rounding headroom
	function automatic int cps_tmag_w(input int cb, input int fb);
		return cb + fb + 2;
	endfunction

endpackage

`default_nettype wire

>>> rtl/cps_dot.sv
// ----------------------------------------------------------------------------
// cps_dot: difference vectors and dot products
// Four stages: differences, products, sums, magnitude and degenerate test.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_dot #(
	parameter int CB = cps_pkg::CPS_COORD_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   vld_i,
	input  wire logic [2:0][CB-1:0]                     a_i,
	input  wire logic [2:0][CB-1:0]                     b_i,
	input  wire logic [2:0][CB-1:0]                     q_i,
	output logic                                        vld_o,
	output logic [cps_pkg::cps_dot_w(CB)-1:0]           num_mag_o,
	output logic                                        num_neg_o,
	output logic [cps_pkg::cps_dot_w(CB)-1:0]           den_o,
	output logic                                        deg_o,
	output logic [2:0][CB-1:0]                          a_o,
	output logic [2:0][cps_pkg::cps_diff_w(CB)-1:0]     d_o
);
	import cps_pkg::*;

	localparam int DD = cps_diff_w(CB);
	localparam int PW = 2 * DD;
	localparam int SW = PW + 2;
	localparam int MW = cps_dot_w(CB);

	logic [3:0]                  vld_q;
	logic [2:0][CB-1:0]          a_s1, a_s2, a_s3, a_s4;
	logic signed [DD-1:0]        d_s1 [3];
	logic signed [DD-1:0]        e_s1 [3];
	logic [2:0][DD-1:0]          d_s2, d_s3, d_s4;
	logic signed [PW-1:0]        pn_s2 [3];
	logic signed [PW-1:0]        pd_s2 [3];
	logic signed [SW-1:0]        num_s3, den_s3;
	logic [MW-1:0]               mag_s4, den_s4;
	logic                        neg_s4, deg_s4;
	logic signed [SW-1:0]        num_c, den_c, abs_c;

	always_comb begin
		num_c = SW'(pn_s2[0]) + SW'(pn_s2[1]) + SW'(pn_s2[2]);
		den_c = SW'(pd_s2[0]) + SW'(pd_s2[1]) + SW'(pd_s2[2]);
		abs_c = num_s3[SW-1] ? -num_s3 : num_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {b_i[i][CB-1], b_i[i]} - {a_i[i][CB-1], a_i[i]};
				e_s1[i] <= {q_i[i][CB-1], q_i[i]} - {a_i[i][CB-1], a_i[i]};
				pn_s2[i] <= e_s1[i] * d_s1[i];
				pd_s2[i] <= d_s1[i] * d_s1[i];
				d_s2[i] <= d_s1[i];
			end
			a_s1   <= a_i;
			a_s2   <= a_s1;
			num_s3 <= num_c;
			den_s3 <= den_c;
			d_s3   <= d_s2;
			a_s3   <= a_s2;
			mag_s4 <= abs_c[MW-1:0];
			neg_s4 <= num_s3[SW-1];
			den_s4 <= den_s3[MW-1:0];
			deg_s4 <= (den_s3 == '0);
			d_s4   <= d_s3;
			a_s4   <= a_s3;
		end
	end

	assign vld_o     = vld_q[3];
	assign num_mag_o = mag_s4;
	assign num_neg_o = neg_s4;
	assign den_o     = den_s4;
	assign deg_o     = deg_s4;
	assign a_o       = a_s4;
	assign d_o       = d_s4;

endmodule

`default_nettype wire

>>> rtl/cps_div_cell.sv
// ----------------------------------------------------------------------------
// cps_div_cell: one restoring division step
// Shifts in one dividend bit, subtracts the divisor if it fits, and hands
// remainder, quotient/dividend word and sideband to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_div_cell #(
	parameter int DW  = 66,
	parameter int NW  = 82,
	parameter int SBW = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld_i,
	input  wire logic [DW-1:0]  rem_i,
	input  wire logic [NW-1:0]  n_i,
	input  wire logic [DW-1:0]  den_i,
	input  wire logic [SBW-1:0] sb_i,
	output logic                vld_o,
	output logic [DW-1:0]       rem_o,
	output logic [NW-1:0]       n_o,
	output logic [DW-1:0]       den_o,
	output logic [SBW-1:0]      sb_o
);

	logic [DW:0] trial, diff;
	logic        ge;

	always_comb begin
		trial = {rem_i, n_i[NW-1]};
		diff  = trial - {1'b0, den_i};
		ge    = (trial >= {1'b0, den_i});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[DW-1:0] : trial[DW-1:0];
			n_o   <= {n_i[NW-2:0], ge};
			den_o <= den_i;
			sb_o  <= sb_i;
		end
	end

endmodule

`default_nettype wire

>>> rtl/cps_fin.sv
// ----------------------------------------------------------------------------
// cps_fin: rounding, clamp, point reconstruction, saturation
// Five stages; the last one is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_fin #(
	parameter int CB = cps_pkg::CPS_COORD_BITS,
	parameter int FB = cps_pkg::CPS_FRAC_BITS
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      en,
	input  wire logic                                      clamp_i,
	input  wire logic                                      vld_i,
	input  wire logic [2*cps_pkg::cps_dot_w(CB)-1+FB-cps_pkg::cps_dot_w(CB)+1-1:0] q_i,
	input  wire logic [cps_pkg::cps_dot_w(CB)-1:0]         rem_i,
	input  wire logic [cps_pkg::cps_dot_w(CB)-1:0]         den_i,
	input  wire logic                                      neg_i,
	input  wire logic                                      deg_i,
	input  wire logic [2:0][CB-1:0]                        a_i,
	input  wire logic [2:0][cps_pkg::cps_diff_w(CB)-1:0]   d_i,
	output logic                                           vld_o,
	output logic [2:0][CB-1:0]                             p_o,
	output logic [CB-1:0]                                  t_o,
	output logic                                           deg_o
);
	import cps_pkg::*;

	localparam int DW  = cps_dot_w(CB);
	localparam int DD  = cps_diff_w(CB);
	localparam int TW  = cps_tmag_w(CB, FB);
	localparam int HW  = TW / 2;
	localparam int PRW = TW + DD + 1;
	localparam int SHW = PRW - FB;
	localparam int VW  = SHW + 2;

	logic [4:0]                 vld_q;
	logic [TW-1:0]              tm_s1, tm_s2;
	logic                       neg_s1, tn_s2;
	logic [3:0]                 deg_q;
	logic [2:0][CB-1:0]         a_s1, a_s2, a_s3, a_s4;
	logic [2:0][DD-1:0]         d_s1, d_s2;
	logic [HW+DD-1:0]           plo_s3 [3];
	logic [TW-HW+DD-1:0]        phi_s3 [3];
	logic [2:0]                 sg_s3, sg_s4;
	logic [CB-1:0]              t_s3, t_s4;
	logic [SHW-1:0]             mag_s4 [3];
	logic [2:0][CB-1:0]         p_q;
	logic [CB-1:0]              t_q;
	logic                       deg_out_q;

	logic                       inc;
	logic [TW-1:0]              tc_mag;
	logic                       tc_neg;
	logic [DD-1:0]              dmag [3];
	logic [CB-1:0]              tsat;
	logic [PRW-1:0]             full [3];
	logic signed [VW-1:0]       val [3];
	logic [CB-1:0]              psat [3];

	localparam logic [TW-1:0]  ONE  = TW'(1) << FB;
	localparam logic [TW-1:0]  TMAX = (TW'(1) << (CB - 1)) - TW'(1);
	localparam logic [TW-1:0]  TMIN = TW'(1) << (CB - 1);
	localparam logic [CB-1:0]  CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0]  CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [VW-1:0] VMAX = VW'(CMAX);
	localparam logic signed [VW-1:0] VMIN = -(VW'(1) << (CB - 1));
	localparam logic [PRW-1:0] HALF = PRW'(1) << (FB - 1);

	always_comb begin
		inc = ({rem_i, 1'b0} >= {1'b0, den_i});
		if (clamp_i) begin
			tc_neg = 1'b0;
			if (neg_s1)          tc_mag = '0;
			else if (tm_s1 > ONE) tc_mag = ONE;
			else                  tc_mag = tm_s1;
		end else begin
			tc_neg = neg_s1 && (tm_s1 != '0);
			tc_mag = tm_s1;
		end
		if (!tn_s2 && tm_s2 > TMAX)      tsat = CMAX;
		else if (tn_s2 && tm_s2 > TMIN)  tsat = CMIN;
		else if (tn_s2)                  tsat = CB'(-tm_s2);
		else                             tsat = tm_s2[CB-1:0];
		for (int i = 0; i < 3; i++) begin
			dmag[i] = d_s2[i][DD-1] ? -d_s2[i] : d_s2[i];
			full[i] = (PRW'(phi_s3[i]) << HW) + PRW'(plo_s3[i]) + HALF;
			val[i]  = (sg_s4[i] ? -VW'(mag_s4[i]) : VW'(mag_s4[i]))
			        + VW'($signed(a_s4[i]));
			if (val[i] > VMAX)      psat[i] = CMAX;
			else if (val[i] < VMIN) psat[i] = CMIN;
			else                    psat[i] = val[i][CB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[3:0], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: round to nearest, ties away
			tm_s1  <= q_i[TW-1:0] + TW'(inc);
			neg_s1 <= neg_i;
			a_s1   <= a_i;
			d_s1   <= d_i;
			// s2: clamp
			tm_s2  <= tc_mag;
			tn_s2  <= tc_neg;
			a_s2   <= a_s1;
			d_s2   <= d_s1;
			// s3: split products
			for (int i = 0; i < 3; i++) begin
				plo_s3[i] <= tm_s2[HW-1:0] * dmag[i];
				phi_s3[i] <= tm_s2[TW-1:HW] * dmag[i];
				sg_s3[i]  <= tn_s2 ^ d_s2[i][DD-1];
				mag_s4[i] <= full[i][PRW-1:FB];
			end
			t_s3  <= tsat;
			a_s3  <= a_s2;
			// s4: sum and scale
			sg_s4 <= sg_s3;
			t_s4  <= t_s3;
			a_s4  <= a_s3;
			deg_q <= {deg_q[2:0], deg_i};
			// s5: output
			deg_out_q <= deg_q[3];
			t_q <= deg_q[3] ? '0 : t_s4;
			for (int i = 0; i < 3; i++) begin
				p_q[i] <= deg_q[3] ? a_s4[i] : psat[i];
			end
		end
	end

	assign vld_o = vld_q[4];
	assign p_o   = p_q;
	assign t_o   = t_q;
	assign deg_o = deg_out_q;

endmodule

`default_nettype wire

>>> rtl/closest_point_on_segment.sv
// ----------------------------------------------------------------------------
// closest_point_on_segment: projection of a point onto a 3D segment
// Fully pipelined fixed-point closest point on segment AB to query point Q.
// ----------------------------------------------------------------------------
// One request per clock, sustained while no result is held by out_stall. The
// pipe runs through the dot-product stages, then the divider (a row of
// identical restoring cells, one quotient bit each), then the finish stages.
// The input side has a one-entry skid register, so a request is still taken
// while a result waits on out_stall; in_stall comes straight from a flop.
// t = dot(Q-A,B-A)/dot(B-A,B-A) is rounded to nearest (ties away from zero)
// at FRAC_BITS fraction bits, clamped to [0,1] when clamp_enable is set,
// and P = A + t*(B-A). P and t saturate to the signed coordinate range.
// A segment with A equal to B returns P = A, t = 0, degenerate = 1.
// clamp_enable (cfg_we/cfg_wdata, reset 1) is sampled late in the pipe, so
// write it only with the pipe empty.
`default_nettype none

module closest_point_on_segment #(
	parameter int COORD_BITS = cps_pkg::CPS_COORD_BITS,
	parameter int FRAC_BITS  = cps_pkg::CPS_FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] a_x,
	input  wire logic signed [COORD_BITS-1:0] a_y,
	input  wire logic signed [COORD_BITS-1:0] a_z,
	input  wire logic signed [COORD_BITS-1:0] b_x,
	input  wire logic signed [COORD_BITS-1:0] b_y,
	input  wire logic signed [COORD_BITS-1:0] b_z,
	input  wire logic signed [COORD_BITS-1:0] q_x,
	input  wire logic signed [COORD_BITS-1:0] q_y,
	input  wire logic signed [COORD_BITS-1:0] q_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [COORD_BITS-1:0]      p_x,
	output logic signed [COORD_BITS-1:0]      p_y,
	output logic signed [COORD_BITS-1:0]      p_z,
	output logic signed [COORD_BITS-1:0]      t_param,
	output logic                              degenerate
);
	import cps_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int DD  = cps_diff_w(CB);
	localparam int DW  = cps_dot_w(CB);
	localparam int NW  = DW + FRAC_BITS;
	localparam int SBW = 2 + 3 * CB + 3 * DD;

	// clamp register
	logic clamp_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= 1'b1;
		end else if (cfg_we) begin
			clamp_q <= cfg_wdata;
		end
	end

	// whole pipe moves unless the output register holds a stalled result
	logic adv;
	assign adv = !(out_valid && out_stall);

	// input skid register
	logic               skid_full_q;
	logic [2:0][CB-1:0] skid_a_q, skid_b_q, skid_q_q;
	logic               acc;
	logic [2:0][CB-1:0] src_a, src_b, src_q;

	assign acc      = in_valid && !skid_full_q;
	assign in_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (adv) begin
			skid_full_q <= 1'b0;
		end else if (acc) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !adv) begin
			skid_a_q <= {a_z, a_y, a_x};
			skid_b_q <= {b_z, b_y, b_x};
			skid_q_q <= {q_z, q_y, q_x};
		end
	end

	assign src_a = skid_full_q ? skid_a_q : {a_z, a_y, a_x};
	assign src_b = skid_full_q ? skid_b_q : {b_z, b_y, b_x};
	assign src_q = skid_full_q ? skid_q_q : {q_z, q_y, q_x};

	// dot products
	logic               dot_vld, dot_neg, dot_deg;
	logic [DW-1:0]      dot_mag, dot_den;
	logic [2:0][CB-1:0] dot_a;
	logic [2:0][DD-1:0] dot_d;

	cps_dot #(.CB(CB)) u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.vld_i     (skid_full_q || acc),
		.a_i       (src_a),
		.b_i       (src_b),
		.q_i       (src_q),
		.vld_o     (dot_vld),
		.num_mag_o (dot_mag),
		.num_neg_o (dot_neg),
		.den_o     (dot_den),
		.deg_o     (dot_deg),
		.a_o       (dot_a),
		.d_o       (dot_d)
	);

	// divider: row of restoring cells, one quotient bit per cell
	logic           vld_c [NW+1];
	logic [DW-1:0]  rem_c [NW+1];
	logic [NW-1:0]  n_c   [NW+1];
	logic [DW-1:0]  den_c [NW+1];
	logic [SBW-1:0] sb_c  [NW+1];

	assign vld_c[0] = dot_vld;
	assign rem_c[0] = '0;
	assign n_c[0]   = {dot_mag, {FRAC_BITS{1'b0}}};
	assign den_c[0] = dot_den;
	assign sb_c[0]  = {dot_deg, dot_neg, dot_a, dot_d};

	for (genvar k = 0; k < NW; k++) begin : g_cell
		cps_div_cell #(.DW(DW), .NW(NW), .SBW(SBW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (vld_c[k]),
			.rem_i  (rem_c[k]),
			.n_i    (n_c[k]),
			.den_i  (den_c[k]),
			.sb_i   (sb_c[k]),
			.vld_o  (vld_c[k+1]),
			.rem_o  (rem_c[k+1]),
			.n_o    (n_c[k+1]),
			.den_o  (den_c[k+1]),
			.sb_o   (sb_c[k+1])
		);
	end

	// finish: round, clamp, rebuild point, saturate
	logic [SBW-1:0]     sb_end;
	logic [2:0][CB-1:0] fin_p;
	logic [2:0][CB-1:0] end_a;
	logic [2:0][DD-1:0] end_d;

	assign sb_end = sb_c[NW];
	assign end_d  = sb_end[3*DD-1:0];
	assign end_a  = sb_end[3*DD +: 3*CB];

	cps_fin #(.CB(CB), .FB(FRAC_BITS)) u_fin (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.clamp_i (clamp_q),
		.vld_i   (vld_c[NW]),
		.q_i     (n_c[NW]),
		.rem_i   (rem_c[NW]),
		.den_i   (den_c[NW]),
		.neg_i   (sb_end[SBW-2]),
		.deg_i   (sb_end[SBW-1]),
		.a_i     (end_a),
		.d_i     (end_d),
		.vld_o   (out_valid),
		.p_o     (fin_p),
		.t_o     (t_param),
		.deg_o   (degenerate)
	);

	assign p_x = fin_p[0];
	assign p_y = fin_p[1];
	assign p_z = fin_p[2];

endmodule

`default_nettype wire

>>> rtl/cps_chk.sv
// ----------------------------------------------------------------------------
// cps_chk: port-level checks for closest_point_on_segment
// Handshake and skid behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_chk #(
	parameter int CB = cps_pkg::CPS_COORD_BITS
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic signed [CB-1:0] p_x,
	input wire logic signed [CB-1:0] t_param,
	input wire logic                 degenerate
);

	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(p_x) && $stable(t_param))
		else $error("stalled result changed");

	ap_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	ap_deg_t: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> t_param == '0)
		else $error("degenerate request with nonzero t");

	ap_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> !in_stall)
		else $error("skid not drained while pipe moved");

	ap_skid_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && in_stall |=> !in_stall)
		else $error("input held off after result taken");

endmodule

bind closest_point_on_segment cps_chk #(.CB(COORD_BITS)) u_cps_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.p_x        (p_x),
	.t_param    (t_param),
	.degenerate (degenerate)
);

`default_nettype wire
